// ===== src/gpsm_pkg.sv =====
// Shared types, register codes and constants of the gamepad poll master.
package gpsm_pkg;

  // Default number of stored frame bytes (received after the header)
  localparam int unsigned FRAME_BYTES_DEF = 9;

  // Fixed byte sent first in every frame
  localparam logic [7:0] HEADER_BYTE = 8'h01;

  // Config register reset values
  localparam logic [15:0] LOW_HALF_RST = 16'd100;
  localparam logic [15:0] HIGH_RST     = 16'd200;
  localparam logic [15:0] GAP_RST      = 16'd200;
  localparam logic [15:0] LEAD_RST     = 16'd1000;
  localparam logic [7:0]  POLL_RST     = 8'h42;
  localparam logic [7:0]  FILLER_RST   = 8'h55;

  // Config register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_HALF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILLER   = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  // Stream widths: input tdata {data_in, start_req}, output tdata packed result
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEAD = 3'd1,
    PH_LOW1 = 3'd2,
    PH_LOW2 = 3'd3,
    PH_HIGH = 3'd4,
    PH_GAP  = 3'd5
  } phase_e;

  // Live configuration
  typedef struct packed {
    logic [15:0] low_half_ticks;
    logic [15:0] high_ticks;
    logic [15:0] byte_gap_ticks;
    logic [15:0] att_lead_ticks;
    logic [7:0]  poll_command;
    logic [7:0]  filler_byte;
  } cfg_t;

  // One result item per tick
  typedef struct packed {
    logic       att_n;
    logic       clk_out;
    logic       cmd_out;
    logic       byte_valid;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic       frame_done;
    logic       busy_res;
  } res_t;

endpackage

// ===== src/gpsm_cfg_regs.sv =====
// Configuration register file of the gamepad poll master.
module gpsm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [gpsm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gpsm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output gpsm_pkg::cfg_t                cfg_o
);
  import gpsm_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index and merge the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LOW_HALF: cfg_d.low_half_ticks = cfg_data_i;
        REG_HIGH:     cfg_d.high_ticks     = cfg_data_i;
        REG_GAP:      cfg_d.byte_gap_ticks = cfg_data_i;
        REG_LEAD:     cfg_d.att_lead_ticks = cfg_data_i;
        REG_POLL:     cfg_d.poll_command   = cfg_data_i[7:0];
        REG_FILLER:   cfg_d.filler_byte    = cfg_data_i[7:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_half_ticks <= LOW_HALF_RST;
      cfg_q.high_ticks     <= HIGH_RST;
      cfg_q.byte_gap_ticks <= GAP_RST;
      cfg_q.att_lead_ticks <= LEAD_RST;
      cfg_q.poll_command   <= POLL_RST;
      cfg_q.filler_byte    <= FILLER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/gpsm_core.sv =====
// Poll sequencer: phase, tick, bit and byte counters and the receive shifter.
module gpsm_core #(
  parameter int unsigned FRAME_BYTES = gpsm_pkg::FRAME_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           start_req_i,
  input  logic           data_in_i,
  input  gpsm_pkg::cfg_t cfg_i,
  output gpsm_pkg::res_t res_o
);
  import gpsm_pkg::*;

  localparam int unsigned BCW = $clog2(FRAME_BYTES + 2);
  localparam logic [BCW-1:0] LAST_BYTE = BCW'(FRAME_BYTES + 1);

  phase_e         phase_q, phase_d;
  logic [15:0]    tick_q, tick_d;
  logic [2:0]     bit_q, bit_d;
  logic [BCW-1:0] byte_q, byte_d;
  logic [7:0]     shift_q, shift_d;

  logic           byte_done, frame_end;
  logic [BCW-1:0] byte_inc;
  logic [15:0]    low_load, high_load;
  logic           tick_more;
  logic [BCW+3:0] idx_ext;
  logic [7:0]     tx_byte;
  logic           bit_phase;

  // Zero low or high counts act as one tick
  assign low_load  = (cfg_i.low_half_ticks == '0) ? 16'd1 : cfg_i.low_half_ticks;
  assign high_load = (cfg_i.high_ticks == '0) ? 16'd1 : cfg_i.high_ticks;
  assign tick_more = |tick_q[15:1];
  assign byte_inc  = byte_q + BCW'(1);

  // Next state of the sequencer for one tick
  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    shift_d   = shift_q;
    byte_done = 1'b0;
    frame_end = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          byte_d  = '0;
          bit_d   = '0;
          shift_d = '0;
          if (cfg_i.att_lead_ticks != '0) begin
            phase_d = PH_LEAD;
            tick_d  = cfg_i.att_lead_ticks;
          end else begin
            phase_d = PH_LOW1;
            tick_d  = low_load;
          end
        end
      end
      PH_LEAD: begin
        if (tick_more) begin
          tick_d = tick_q - 16'd1;
        end else begin
          phase_d = PH_LOW1;
          tick_d  = low_load;
        end
      end
      PH_LOW1: begin
        if (tick_more) begin
          tick_d = tick_q - 16'd1;
        end else begin
          shift_d = {data_in_i, shift_q[7:1]};
          phase_d = PH_LOW2;
          tick_d  = low_load;
        end
      end
      PH_LOW2: begin
        if (tick_more) begin
          tick_d = tick_q - 16'd1;
        end else begin
          phase_d = PH_HIGH;
          tick_d  = high_load;
        end
      end
      PH_HIGH: begin
        if (tick_more) begin
          tick_d = tick_q - 16'd1;
        end else if (bit_q != 3'd7) begin
          bit_d   = bit_q + 3'd1;
          phase_d = PH_LOW1;
          tick_d  = low_load;
        end else begin
          // Report every byte after the header
          byte_done = (byte_q != '0);
          if (cfg_i.byte_gap_ticks != '0) begin
            phase_d = PH_GAP;
            tick_d  = cfg_i.byte_gap_ticks;
          end else begin
            byte_d = byte_inc;
            if (byte_inc >= LAST_BYTE) begin
              phase_d   = PH_IDLE;
              tick_d    = '0;
              frame_end = 1'b1;
            end else begin
              bit_d   = '0;
              phase_d = PH_LOW1;
              tick_d  = low_load;
            end
          end
        end
      end
      PH_GAP: begin
        if (tick_more) begin
          tick_d = tick_q - 16'd1;
        end else begin
          byte_d = byte_inc;
          if (byte_inc >= LAST_BYTE) begin
            phase_d   = PH_IDLE;
            tick_d    = '0;
            frame_end = 1'b1;
          end else begin
            bit_d   = '0;
            phase_d = PH_LOW1;
            tick_d  = low_load;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  assign idx_ext = {4'b0000, byte_q - BCW'(1)};

  // Byte on the command line, chosen by the updated byte count
  always_comb begin
    if (byte_d == BCW'(0)) begin
      tx_byte = HEADER_BYTE;
    end else if (byte_d == BCW'(1)) begin
      tx_byte = cfg_i.poll_command;
    end else begin
      tx_byte = cfg_i.filler_byte;
    end
  end

  assign bit_phase = (phase_d == PH_LOW1) || (phase_d == PH_LOW2) || (phase_d == PH_HIGH);

  // Pin levels and report fields after this tick's update
  always_comb begin
    res_o.att_n      = (phase_d == PH_IDLE);
    res_o.clk_out    = !((phase_d == PH_LOW1) || (phase_d == PH_LOW2));
    res_o.cmd_out    = bit_phase ? tx_byte[bit_d] : 1'b1;
    res_o.byte_valid = byte_done;
    res_o.byte_index = byte_done ? idx_ext[3:0] : 4'd0;
    res_o.byte_value = byte_done ? shift_q : 8'd0;
    res_o.frame_done = frame_end;
    res_o.busy_res   = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
    end
  end

endmodule

// ===== src/gamepad_poll_serial_master_top.sv =====
// Top level of the gamepad poll master: input register, sequencer, result register.
// Flow: a tick item accepted into the input register is stepped once the result
//   slot is free, and its result item is then held valid in the result register.
// Throughput: one tick item per cycle while the result side takes them; input
//   and result registers each pass an item per cycle, one sequencer step per tick.
// Reset (rst_ni low, asynchronous): both stream stages empty, sequencer idle
//   with cleared counters and shifter, config registers at their default values.
module gamepad_poll_serial_master_top #(
  parameter int unsigned FRAME_BYTES = gpsm_pkg::FRAME_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Tick items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] start_req, [1] data_in, [7:2] zero
  input  logic [gpsm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] att_n, [1] clk_out, [2] cmd_out, [3] byte_valid, [7:4] byte_index,
  // [15:8] byte_value, [16] busy_res, [23:17] zero
  output logic [gpsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // frame_done
  output logic                           m_axis_tlast,
  // Config writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gpsm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gpsm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import gpsm_pkg::*;

  cfg_t cfg;
  res_t res, res_q;
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic start_q, din_q;
  logic step;
  logic in_fire;

  assign cfg_ready_o = 1'b1;

  gpsm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Step the sequencer when a tick is held and the result slot frees up
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  gpsm_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .start_req_i (start_q),
    .data_in_i   (din_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  // Hold or advance the stage valid flags
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      start_q <= s_axis_tdata[0];
      din_q   <= s_axis_tdata[1];
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.frame_done;
  assign m_axis_tdata  = {7'b0000000, res_q.busy_res, res_q.byte_value, res_q.byte_index,
                          res_q.byte_valid, res_q.cmd_out, res_q.clk_out, res_q.att_n};

  // Attention is low exactly while a frame runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_q.busy_res != res_q.att_n))
    else $error("busy and attention disagree");

  // Byte fields are zero unless a byte is reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_q.byte_valid) |-> (res_q.byte_index == 4'd0 &&
                                              res_q.byte_value == 8'd0))
    else $error("byte fields set without a byte");

  // End of frame leaves the bus idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.frame_done) |-> (res_q.att_n && res_q.clk_out &&
                                             res_q.cmd_out))
    else $error("frame end with bus not idle");

  // Serial clock only goes low inside a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_q.clk_out) |-> !res_q.att_n)
    else $error("clock low outside a frame");

endmodule
